### hdl/trpd_pkg.sv
`default_nettype none

package trpd_pkg;

  // Field widths
  localparam int unsigned TickW    = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned StoreW   = 18;
  localparam int unsigned WordW    = 16;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [PeriodW-1:0] PeriodSat  = 16'hFFFF;
  localparam logic [CountW-1:0]  SyncBits   = 5'd2;
  localparam logic [CountW:0]    FrameBits  = 6'd20;
  localparam logic [CountW-1:0]  StoreLimit = 5'd18;

  // Phase codes as reported on the result beat
  localparam logic [PhaseW-1:0] PhaseCodeIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhaseCodeRead = 2'd1;
  localparam logic [PhaseW-1:0] PhaseCodeDone = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_READ = 3'b010,
    PH_DONE = 3'b100
  } phase_e;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_MIN  = 3'd0,
    REG_SHORT_MAX  = 3'd1,
    REG_LONG_MIN   = 3'd2,
    REG_LONG_MAX   = 3'd3,
    REG_PILOT_MIN  = 3'd4,
    REG_GLITCH     = 3'd5,
    REG_OPEN_VALUE = 3'd6,
    REG_OPEN_POL   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] short_min;
    logic [PeriodW-1:0] short_max;
    logic [PeriodW-1:0] long_min;
    logic [PeriodW-1:0] long_max;
    logic [PeriodW-1:0] pilot_min;
    logic [PeriodW-1:0] glitch_ticks;
    logic               open_as_value;
    logic               open_mask_polarity;
  } trpd_cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [CountW-1:0]  bit_count;
    logic               half_seen;
    logic               first_symbol;
    logic [TickW-1:0]   last_edge_time;
    logic [PeriodW-1:0] low_period;
    logic [PeriodW-1:0] high_period;
    logic [StoreW-1:0]  level_bits;
    logic [StoreW-1:0]  open_bits;
  } trpd_state_t;

  typedef struct packed {
    logic              frame_ready;
    logic [WordW-1:0]  data_word;
    logic [WordW-1:0]  open_mask;
    logic [PhaseW-1:0] decoder_phase;
  } trpd_result_t;

  localparam trpd_state_t StateClear = '{
    phase:          PH_IDLE,
    bit_count:      '0,
    half_seen:      1'b0,
    first_symbol:   1'b0,
    last_edge_time: '0,
    low_period:     '0,
    high_period:    '0,
    level_bits:     '0,
    open_bits:      '0
  };

endpackage

`default_nettype wire

### hdl/trpd_cfg.sv
`default_nettype none

module trpd_cfg import trpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output trpd_cfg_t                cfg_o
);

  trpd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_SHORT_MIN:  cfg_d.short_min          = cfg_wdata_i;
        REG_SHORT_MAX:  cfg_d.short_max          = cfg_wdata_i;
        REG_LONG_MIN:   cfg_d.long_min           = cfg_wdata_i;
        REG_LONG_MAX:   cfg_d.long_max           = cfg_wdata_i;
        REG_PILOT_MIN:  cfg_d.pilot_min          = cfg_wdata_i;
        REG_GLITCH:     cfg_d.glitch_ticks       = cfg_wdata_i;
        REG_OPEN_VALUE: cfg_d.open_as_value      = cfg_wdata_i[0];
        REG_OPEN_POL:   cfg_d.open_mask_polarity = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        short_min: '0, short_max: '0, long_min: '0, long_max: '0,
        pilot_min: '0, glitch_ticks: '0,
        open_as_value: 1'b0, open_mask_polarity: 1'b1
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/trpd_core.sv
`default_nettype none

// Next-state and result logic for one beat: period measurement, pulse
// classification, symbol pairing and bit store update.
module trpd_core import trpd_pkg::*; (
  input  wire trpd_cfg_t          cfg_i,
  input  wire trpd_state_t        state_i,
  input  wire logic               op_i,
  input  wire logic               pin_level_i,
  input  wire logic [TickW-1:0]   timestamp_i,
  output trpd_state_t             state_o,
  output trpd_result_t            result_o
);

  logic [TickW-1:0]   delta;
  logic [PeriodW-1:0] period;
  logic               short_h, short_l, long_h, long_l, pilot;
  logic               sym0, sym1, sym;
  logic [CountW-1:0]  k;
  logic [StoreW-1:0]  m;
  logic [CountW:0]    count_inc;
  trpd_state_t        s;

  assign delta  = timestamp_i - state_i.last_edge_time;
  assign period = (delta > TickW'(PeriodSat)) ? PeriodSat : delta[PeriodW-1:0];

  // Classification uses the new high period together with the stored low one.
  assign short_h = (period >= cfg_i.short_min) && (period <= cfg_i.short_max);
  assign long_h  = (period >= cfg_i.long_min)  && (period <= cfg_i.long_max);
  assign short_l = (state_i.low_period >= cfg_i.short_min) &&
                   (state_i.low_period <= cfg_i.short_max);
  assign long_l  = (state_i.low_period >= cfg_i.long_min) &&
                   (state_i.low_period <= cfg_i.long_max);
  assign pilot   = (state_i.low_period > cfg_i.pilot_min) && short_h;
  assign sym0    = short_l && long_h;
  assign sym1    = !sym0 && long_l && short_h;
  assign sym     = sym1;

  assign k         = state_i.bit_count - SyncBits;
  assign m         = (k < StoreLimit) ? (StoreW'(1) << k) : '0;
  assign count_inc = {1'b0, state_i.bit_count} + 6'd1;

  always_comb begin
    s = state_i;
    if (op_e'(op_i) == OP_CLEAR) begin
      s = StateClear;
    end else if (state_i.phase != PH_DONE && delta >= TickW'(cfg_i.glitch_ticks)) begin
      s.last_edge_time = timestamp_i;
      if (pin_level_i) begin
        s.low_period = period;
      end else begin
        s.high_period = period;
        if (state_i.phase == PH_IDLE) begin
          if (pilot) begin
            s.phase     = PH_READ;
            s.bit_count = '0;
            s.half_seen = 1'b0;
          end
        end else if (!(sym0 || sym1)) begin
          if (pilot) begin
            s.phase     = PH_READ;
            s.bit_count = '0;
            s.half_seen = 1'b0;
          end else begin
            s.phase = PH_IDLE;
          end
        end else if (!state_i.half_seen) begin
          s.half_seen    = 1'b1;
          s.first_symbol = sym;
        end else begin
          s.half_seen = 1'b0;
          if (state_i.bit_count < SyncBits) begin
            // Sync bits must be a short/long pair followed by long/short.
            if (!state_i.first_symbol && sym) begin
              s.bit_count = count_inc[CountW-1:0];
            end else begin
              s.phase = PH_IDLE;
            end
          end else if (!state_i.first_symbol && sym) begin
            s.phase = PH_IDLE;
          end else begin
            if (state_i.first_symbol && sym) begin
              s.level_bits = state_i.level_bits | m;
              s.open_bits  = state_i.open_bits & ~m;
            end else if (state_i.first_symbol) begin
              s.level_bits = state_i.level_bits & ~m;
              s.open_bits  = state_i.open_bits | m;
            end else begin
              s.level_bits = state_i.level_bits & ~m;
              s.open_bits  = state_i.open_bits & ~m;
            end
            s.bit_count = count_inc[CountW-1:0];
            if (count_inc >= FrameBits) begin
              s.phase = PH_DONE;
            end
          end
        end
      end
    end
  end

  assign state_o = s;

  always_comb begin
    for (int i = 0; i < WordW; i++) begin
      result_o.data_word[i] = s.open_bits[i] ? cfg_i.open_as_value : s.level_bits[i];
      result_o.open_mask[i] = (s.open_bits[i] == cfg_i.open_mask_polarity);
    end
    result_o.frame_ready = (s.phase == PH_DONE);
    case (s.phase)
      PH_IDLE: result_o.decoder_phase = PhaseCodeIdle;
      PH_DONE: result_o.decoder_phase = PhaseCodeDone;
      default: result_o.decoder_phase = PhaseCodeRead;
    endcase
  end

endmodule

`default_nettype wire

### hdl/trinary_remote_pulse_decoder_top.sv
// A result beat passes through the input register and then the result register.
// Throughput: one beat per cycle while the result stream is not stalled; the
// decoder state is updated in the same cycle as the result register is loaded,
// so consecutive edges chain freely.
// Reset (rst_ni, asynchronous, active low) empties both stages, clears the
// decoder to idle and returns the threshold registers to their defaults.
`default_nettype none

module trinary_remote_pulse_decoder_top import trpd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream
  input  wire logic                s_tvalid_i,
  output      logic                s_tready_o,
  input  wire logic [InDataW-1:0]  s_tdata_i,   // [0] pin_level, [32:1] timestamp, rest zero
  input  wire logic                s_tuser_i,   // [0] op (0 edge, 1 clear)
  // Result stream
  output      logic                m_tvalid_o,
  input  wire logic                m_tready_i,
  output      logic [OutDataW-1:0] m_tdata_o,   // [0] frame_ready, [16:1] data_word,
                                                // [32:17] open_mask, [34:33] decoder_phase
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  trpd_cfg_t    cfg;
  trpd_state_t  state_q, state_d;
  trpd_result_t result_d, result_q;

  // Input register stage. The payload registers need no reset.
  logic             in_valid_q;
  logic             in_op_q;
  logic             in_level_q;
  logic [TickW-1:0] in_ts_q;
  logic             out_valid_q;
  logic             advance;

  // The held beat moves into the result register whenever that register is
  // empty or its beat is being taken in the same cycle.
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;

  trpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  trpd_core u_core (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .op_i        (in_op_q),
    .pin_level_i (in_level_q),
    .timestamp_i (in_ts_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_op_q    <= s_tuser_i;
      in_level_q <= s_tdata_i[0];
      in_ts_q    <= s_tdata_i[TickW:1];
    end
  end

  // Decoder state only moves when a beat is committed to the result stage,
  // so a stalled output never loses or repeats an update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {
    (OutDataW - (1 + 2 * WordW + PhaseW))'(0),
    result_q.decoder_phase,
    result_q.open_mask,
    result_q.data_word,
    result_q.frame_ready
  };

endmodule

`default_nettype wire
